// File: hw/rtl/assert_macros.svh
// Assertion helpers, used by the encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHECK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mrse_pkg.sv
package mrse_pkg;

    localparam int unsigned CFG_W       = 2;
    localparam int unsigned COORD_W     = 13;
    localparam int unsigned CB_W        = 7;
    localparam int unsigned NUM_DIGITS  = 4;
    localparam int unsigned CB_DIGITS   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned DIG_IDX_W   = $clog2(NUM_DIGITS);
    localparam int unsigned DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int unsigned CB_IDX_W    = $clog2(CB_DIGITS);

    // Reciprocal of ten for coordinates up to 4096.
    localparam int unsigned DIV10_MUL   = 6554;
    localparam int unsigned DIV10_SHIFT = 16;

    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_MOVE    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] BTN_OTHER   = 2'd3;
    localparam logic [1:0] TRACK_OFF   = 2'd0;
    localparam logic [1:0] TRACK_DRAG  = 2'd2;

    localparam logic REG_TRACKING = 1'b0;
    localparam logic REG_ENCODING = 1'b1;

    localparam logic [CB_W-1:0] MOVE_OFFSET  = CB_W'(32);
    localparam logic [CB_W-1:0] LEGACY_BIAS  = CB_W'(32);
    localparam logic [CB_W-1:0] RELEASE_CODE = CB_W'(3);
    localparam logic [COORD_W-1:0] X10_BIAS  = COORD_W'(32);
    localparam logic [COORD_W-1:0] X10_MAX   = COORD_W'(255);

    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_UPPER_M  = 8'h4D;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    typedef enum logic [1:0] {
        ENC_X10   = 2'd0,
        ENC_SGR   = 2'd1,
        ENC_URXVT = 2'd2
    } enc_t;

    typedef logic [3:0] digit_t;

    // One classified event, ready to be serialized.
    typedef struct packed {
        enc_t                           enc;
        logic                           rel_evt;
        logic [7:0]                     x10_cb;
        logic [7:0]                     x10_col;
        logic [7:0]                     x10_row;
        digit_t [CB_DIGITS-1:0]         cb_dig;
        digit_t [NUM_DIGITS-1:0]        col_dig;
        digit_t [NUM_DIGITS-1:0]        row_dig;
        logic [CB_IDX_W-1:0]            cb_top;
        logic [DIG_IDX_W-1:0]           col_top;
        logic [DIG_IDX_W-1:0]           row_top;
    } desc_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_LEAD,
        PH_CB,
        PH_SEMI_COL,
        PH_COL,
        PH_SEMI_ROW,
        PH_ROW,
        PH_FINAL,
        PH_X_CB,
        PH_X_COL,
        PH_X_ROW
    } phase_t;

    function automatic logic [COORD_W-1:0] div10(input logic [COORD_W-1:0] v);
        logic [2*COORD_W-1:0] p;
        p = {{COORD_W{1'b0}}, v} * (2*COORD_W)'(DIV10_MUL);
        return COORD_W'(p >> DIV10_SHIFT);
    endfunction

    function automatic digit_t dec_digit(input logic [COORD_W-1:0] v,
                                         input logic [COORD_W-1:0] q);
        logic [COORD_W-1:0] r;
        r = v - ((q << 3) + (q << 1));
        return r[3:0];
    endfunction

    // Index of the most significant decimal digit.
    function automatic logic [DIG_IDX_W-1:0] dec_top(input logic [COORD_W-1:0] v);
        logic [DIG_IDX_W-1:0] t;
        if (v < COORD_W'(10)) begin
            t = DIG_IDX_W'(0);
        end
        else if (v < COORD_W'(100)) begin
            t = DIG_IDX_W'(1);
        end
        else if (v < COORD_W'(1000)) begin
            t = DIG_IDX_W'(2);
        end
        else begin
            t = DIG_IDX_W'(3);
        end
        return t;
    endfunction

endpackage

// File: hw/rtl/mouse_report_sequence_encoder_core.sv
// Turns mouse events (press, drag move, release) into terminal mouse reports in the X10,
// SGR or URXVT form, one byte per cycle while the consumer pops, the final byte flagged by
// last_byte. Set tracking_mode (register 0) and report_encoding (register 1) while the
// block is idle. Events that produce no report are taken and dropped. A reported event
// is classified on the request cycle; decimal encodings then pass through the digit
// extractor (one divide-by-ten step per field and cycle) before the request enters a queue
// of QueueDepth entries. The byte serializer drains that queue at one byte per cycle while
// the consumer pops, and picks up the next request as the last byte leaves, so a stream of
// events is paced by the report length, 6 to 15 bytes; the extractor overlaps with the
// serializer and never limits a stream, as no report is shorter than an extraction.
`include "assert_macros.svh"

module mouse_report_sequence_encoder_core #(
    parameter int unsigned QueueDepth = mrse_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [mrse_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    cmd,
    input  logic [1:0]                    pressed_button,
    input  logic [2:0]                    held_buttons,
    input  logic [2:0]                    modifier_bits,
    input  logic [11:0]                   col_index,
    input  logic [11:0]                   row_index,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    byte_value,
    output logic                          last_byte
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    mrse_pkg::desc_t    q_data;
    mrse_pkg::desc_t    q_head;

    mrse_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .pressed_button (pressed_button),
        .held_buttons   (held_buttons),
        .modifier_bits  (modifier_bits),
        .col_index      (col_index),
        .row_index      (row_index),
        .q_push         (q_push),
        .q_data         (q_data),
        .q_full         (q_full)
    );

    mrse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_data  (q_data),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    mrse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .byte_value (byte_value),
        .last_byte  (last_byte)
    );

    `CHECK_IMPLY(a_no_push_when_full, clk, rst_n, q_full, !q_push, "push into full queue")
    `CHECK_IMPLY(a_no_pop_when_empty, clk, rst_n, q_empty, !q_pop, "pop from empty queue")
    `CHECK_NEXT(a_push_fills_queue, clk, rst_n, q_push, !q_empty, "queue empty after push")
    `CHECK_IMPLY(a_esc_never_last, clk, rst_n, !empty && byte_value == mrse_pkg::CH_ESC,
                 !last_byte, "report ends on escape byte")

endmodule

// File: hw/rtl/mrse_front.sv
module mrse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [mrse_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    cmd,
    input  logic [1:0]                    pressed_button,
    input  logic [2:0]                    held_buttons,
    input  logic [2:0]                    modifier_bits,
    input  logic [11:0]                   col_index,
    input  logic [11:0]                   row_index,
    output logic                          q_push,
    output mrse_pkg::desc_t               q_data,
    input  logic                          q_full
);

    localparam int unsigned CW = mrse_pkg::COORD_W;
    localparam int unsigned BW = mrse_pkg::CB_W;

    logic [1:0]                         tracking_reg, tracking_next;
    logic [1:0]                         encoding_reg, encoding_next;
    logic [1:0]                         last_button_reg, last_button_next;
    logic                               work_valid_reg, work_valid_next;
    logic [mrse_pkg::DIG_CNT_W-1:0]     cnt_reg, cnt_next;
    mrse_pkg::desc_t                    desc_reg, desc_next;
    logic [BW-1:0]                      cbv_reg, cbv_next;
    logic [CW-1:0]                      colv_reg, colv_next;
    logic [CW-1:0]                      rowv_reg, rowv_next;

    logic                               accept;
    logic                               done;
    logic                               is_press, is_move, is_release;
    logic                               keep;
    logic [1:0]                         btn;
    mrse_pkg::enc_t                     enc;
    logic [CW-1:0]                      col_pos, row_pos, col_off, row_off;
    logic [BW-1:0]                      mod_add, sgr_cb, leg_cb, cb_val;
    logic [mrse_pkg::DIG_IDX_W-1:0]     col_top, row_top;
    logic [mrse_pkg::CB_IDX_W-1:0]      cb_top;
    logic                               overlong;
    logic [CW-1:0]                      col_q, row_q, cb_q;
    logic [mrse_pkg::DIG_IDX_W-1:0]     dig_idx;

    assign done   = (cnt_reg == mrse_pkg::DIG_CNT_W'(mrse_pkg::NUM_DIGITS));
    assign full   = work_valid_reg && !(done && !q_full);
    assign accept = push && !full;
    assign q_push = work_valid_reg && done && !q_full;
    assign q_data = desc_reg;

    // Event classification.
    always_comb
    begin
        is_press   = (cmd == mrse_pkg::CMD_PRESS);
        is_move    = (cmd == mrse_pkg::CMD_MOVE);
        is_release = (cmd == mrse_pkg::CMD_RELEASE);

        case (mrse_pkg::enc_t'(encoding_reg))
            mrse_pkg::ENC_SGR:   enc = mrse_pkg::ENC_SGR;
            mrse_pkg::ENC_URXVT: enc = mrse_pkg::ENC_URXVT;
            default:             enc = mrse_pkg::ENC_X10;
        endcase

        if (is_press) begin
            btn = pressed_button;
        end
        else if (is_move) begin
            if (held_buttons[0]) begin
                btn = 2'd0;
            end
            else if (held_buttons[1]) begin
                btn = 2'd1;
            end
            else begin
                btn = 2'd2;
            end
        end
        else begin
            btn = last_button_reg;
        end

        mod_add = BW'({modifier_bits, 2'b00});
        sgr_cb  = BW'(btn) + (is_move ? mrse_pkg::MOVE_OFFSET : BW'(0)) + mod_add;
        leg_cb  = (is_release ? mrse_pkg::RELEASE_CODE
                              : BW'(btn) + (is_move ? mrse_pkg::MOVE_OFFSET : BW'(0)))
                  + mod_add + mrse_pkg::LEGACY_BIAS;
        cb_val  = (enc == mrse_pkg::ENC_SGR) ? sgr_cb : leg_cb;

        col_pos = CW'(col_index) + CW'(1);
        row_pos = CW'(row_index) + CW'(1);
        col_off = col_pos + mrse_pkg::X10_BIAS;
        row_off = row_pos + mrse_pkg::X10_BIAS;

        col_top = mrse_pkg::dec_top(col_pos);
        row_top = mrse_pkg::dec_top(row_pos);
        cb_top  = (cb_val < BW'(10)) ? mrse_pkg::CB_IDX_W'(0) : mrse_pkg::CB_IDX_W'(1);

        // An SGR report of sixteen bytes does not fit and is dropped.
        overlong = (enc == mrse_pkg::ENC_SGR)
                   && (cb_top == mrse_pkg::CB_IDX_W'(mrse_pkg::CB_DIGITS - 1))
                   && (col_top == mrse_pkg::DIG_IDX_W'(mrse_pkg::NUM_DIGITS - 1))
                   && (row_top == mrse_pkg::DIG_IDX_W'(mrse_pkg::NUM_DIGITS - 1));

        if (tracking_reg == mrse_pkg::TRACK_OFF) begin
            keep = 1'b0;
        end
        else if (is_press) begin
            keep = (pressed_button != mrse_pkg::BTN_OTHER);
        end
        else if (is_move) begin
            keep = (tracking_reg >= mrse_pkg::TRACK_DRAG) && (held_buttons != 3'd0);
        end
        else begin
            keep = is_release;
        end
    end

    // Configuration, remembered button and work register control.
    always_comb
    begin
        tracking_next    = tracking_reg;
        encoding_next    = encoding_reg;
        last_button_next = last_button_reg;
        work_valid_next  = work_valid_reg;
        cnt_next         = cnt_reg;

        if (cfg_write) begin
            if (cfg_index == mrse_pkg::REG_TRACKING) begin
                tracking_next = cfg_data;
            end
            else begin
                encoding_next = cfg_data;
            end
        end

        if (q_push) begin
            work_valid_next = 1'b0;
        end
        else if (work_valid_reg && !done) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (accept) begin
            if (keep && is_press) begin
                last_button_next = pressed_button;
            end
            work_valid_next = keep && !overlong;
            cnt_next = (enc == mrse_pkg::ENC_X10)
                       ? mrse_pkg::DIG_CNT_W'(mrse_pkg::NUM_DIGITS)
                       : '0;
        end
    end

    // Descriptor payload and digit extraction, one digit of each field per cycle.
    always_comb
    begin
        desc_next = desc_reg;
        cbv_next  = cbv_reg;
        colv_next = colv_reg;
        rowv_next = rowv_reg;
        dig_idx   = cnt_reg[mrse_pkg::DIG_IDX_W-1:0];
        col_q     = mrse_pkg::div10(colv_reg);
        row_q     = mrse_pkg::div10(rowv_reg);
        cb_q      = mrse_pkg::div10(CW'(cbv_reg));

        if (accept) begin
            desc_next.enc     = enc;
            desc_next.rel_evt = is_release;
            desc_next.x10_cb  = 8'(cb_val);
            desc_next.x10_col = (col_off > mrse_pkg::X10_MAX) ? 8'hFF : col_off[7:0];
            desc_next.x10_row = (row_off > mrse_pkg::X10_MAX) ? 8'hFF : row_off[7:0];
            desc_next.cb_top  = cb_top;
            desc_next.col_top = col_top;
            desc_next.row_top = row_top;
            cbv_next          = cb_val;
            colv_next         = col_pos;
            rowv_next         = row_pos;
        end
        else if (work_valid_reg && !done) begin
            desc_next.col_dig[dig_idx] = mrse_pkg::dec_digit(colv_reg, col_q);
            desc_next.row_dig[dig_idx] = mrse_pkg::dec_digit(rowv_reg, row_q);
            if (cnt_reg < mrse_pkg::DIG_CNT_W'(mrse_pkg::CB_DIGITS)) begin
                desc_next.cb_dig[cnt_reg[mrse_pkg::CB_IDX_W-1:0]] =
                    mrse_pkg::dec_digit(CW'(cbv_reg), cb_q);
            end
            colv_next = col_q;
            rowv_next = row_q;
            cbv_next  = BW'(cb_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tracking_reg    <= mrse_pkg::TRACK_OFF;
            encoding_reg    <= mrse_pkg::ENC_X10;
            last_button_reg <= 2'd0;
            work_valid_reg  <= 1'b0;
            cnt_reg         <= '0;
        end
        else begin
            tracking_reg    <= tracking_next;
            encoding_reg    <= encoding_next;
            last_button_reg <= last_button_next;
            work_valid_reg  <= work_valid_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        cbv_reg  <= cbv_next;
        colv_reg <= colv_next;
        rowv_reg <= rowv_next;
    end

endmodule

// File: hw/rtl/mrse_queue.sv
module mrse_queue #(
    parameter int unsigned Depth = mrse_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  mrse_pkg::desc_t   q_data,
    output logic              q_full,
    input  logic              q_pop,
    output mrse_pkg::desc_t   q_head,
    output logic              q_empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    mrse_pkg::desc_t    entry_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    assign q_full  = (count_reg == CntW'(Depth));
    assign q_empty = (count_reg == '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !q_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push) begin
            entry_reg[wr_ptr_reg] <= q_data;
        end
    end

endmodule

// File: hw/rtl/mrse_back.sv
module mrse_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mrse_pkg::desc_t   q_head,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        byte_value,
    output logic              last_byte
);

    localparam int unsigned IW = mrse_pkg::DIG_IDX_W;

    mrse_pkg::phase_t   phase_reg, phase_next;
    logic [IW-1:0]      dig_reg, dig_next;
    mrse_pkg::desc_t    cur_reg, cur_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    mrse_pkg::phase_t   adv_phase;
    logic [IW-1:0]      adv_dig;
    logic [7:0]         byte_c;
    logic               last_c;
    logic               slot_free;
    logic               emit;
    logic               load;

    assign empty      = !out_valid_reg;
    assign byte_value = out_byte_reg;
    assign last_byte  = out_last_reg;
    assign slot_free  = !out_valid_reg || pop;
    assign emit       = (phase_reg != mrse_pkg::PH_IDLE) && slot_free;

    always_comb
    begin
        byte_c    = mrse_pkg::CH_ESC;
        last_c    = 1'b0;
        adv_phase = phase_reg;
        adv_dig   = dig_reg;

        case (phase_reg)
            mrse_pkg::PH_ESC:
            begin
                byte_c    = mrse_pkg::CH_ESC;
                adv_phase = mrse_pkg::PH_BRACKET;
            end
            mrse_pkg::PH_BRACKET:
            begin
                byte_c = mrse_pkg::CH_LBRACKET;
                if (cur_reg.enc == mrse_pkg::ENC_URXVT) begin
                    adv_phase = mrse_pkg::PH_CB;
                    adv_dig   = IW'(cur_reg.cb_top);
                end
                else begin
                    adv_phase = mrse_pkg::PH_LEAD;
                end
            end
            mrse_pkg::PH_LEAD:
            begin
                if (cur_reg.enc == mrse_pkg::ENC_SGR) begin
                    byte_c    = mrse_pkg::CH_LT;
                    adv_phase = mrse_pkg::PH_CB;
                    adv_dig   = IW'(cur_reg.cb_top);
                end
                else begin
                    byte_c    = mrse_pkg::CH_UPPER_M;
                    adv_phase = mrse_pkg::PH_X_CB;
                end
            end
            mrse_pkg::PH_CB:
            begin
                byte_c  = mrse_pkg::CH_ZERO
                          + 8'(cur_reg.cb_dig[dig_reg[mrse_pkg::CB_IDX_W-1:0]]);
                adv_dig = dig_reg - 1'b1;
                if (dig_reg == '0) begin
                    adv_phase = mrse_pkg::PH_SEMI_COL;
                end
            end
            mrse_pkg::PH_SEMI_COL:
            begin
                byte_c    = mrse_pkg::CH_SEMI;
                adv_phase = mrse_pkg::PH_COL;
                adv_dig   = cur_reg.col_top;
            end
            mrse_pkg::PH_COL:
            begin
                byte_c  = mrse_pkg::CH_ZERO + 8'(cur_reg.col_dig[dig_reg]);
                adv_dig = dig_reg - 1'b1;
                if (dig_reg == '0) begin
                    adv_phase = mrse_pkg::PH_SEMI_ROW;
                end
            end
            mrse_pkg::PH_SEMI_ROW:
            begin
                byte_c    = mrse_pkg::CH_SEMI;
                adv_phase = mrse_pkg::PH_ROW;
                adv_dig   = cur_reg.row_top;
            end
            mrse_pkg::PH_ROW:
            begin
                byte_c  = mrse_pkg::CH_ZERO + 8'(cur_reg.row_dig[dig_reg]);
                adv_dig = dig_reg - 1'b1;
                if (dig_reg == '0) begin
                    adv_phase = mrse_pkg::PH_FINAL;
                end
            end
            mrse_pkg::PH_FINAL:
            begin
                // Only SGR marks a release with a lower-case terminator.
                byte_c = (cur_reg.enc == mrse_pkg::ENC_SGR && cur_reg.rel_evt)
                         ? mrse_pkg::CH_LOWER_M : mrse_pkg::CH_UPPER_M;
                last_c = 1'b1;
            end
            mrse_pkg::PH_X_CB:
            begin
                byte_c    = cur_reg.x10_cb;
                adv_phase = mrse_pkg::PH_X_COL;
            end
            mrse_pkg::PH_X_COL:
            begin
                byte_c    = cur_reg.x10_col;
                adv_phase = mrse_pkg::PH_X_ROW;
            end
            mrse_pkg::PH_X_ROW:
            begin
                byte_c = cur_reg.x10_row;
                last_c = 1'b1;
            end
            default:
            begin
                byte_c = mrse_pkg::CH_ESC;
                last_c = 1'b0;
            end
        endcase

        // A new request is taken when idle or right as the last byte leaves.
        load  = !q_empty && ((phase_reg == mrse_pkg::PH_IDLE) || (emit && last_c));
        q_pop = load;

        phase_next     = phase_reg;
        dig_next       = dig_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (emit) begin
            phase_next     = last_c ? mrse_pkg::PH_IDLE : adv_phase;
            dig_next       = adv_dig;
            out_valid_next = 1'b1;
            out_byte_next  = byte_c;
            out_last_next  = last_c;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end

        if (load) begin
            phase_next = mrse_pkg::PH_ESC;
            cur_next   = q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= mrse_pkg::PH_IDLE;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            dig_reg       <= dig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule
